FILE: design/ppl_pkg.sv
package ppl_pkg;

	localparam int RECS_PER_BUFFER = 256;
	localparam int WORDS_PER_REC   = 7;
	localparam int WORD_W          = 32;
	localparam int ROW_W           = WORDS_PER_REC * WORD_W;
	localparam int SLOT_W          = $clog2(RECS_PER_BUFFER);
	localparam int FILL_W          = $clog2(RECS_PER_BUFFER + 1);
	localparam int ROWS            = 2 * RECS_PER_BUFFER;
	localparam int ADDR_W          = $clog2(ROWS);
	localparam int WIDX_W          = $clog2(WORDS_PER_REC);
	localparam int FILL_OUT_W      = 9;

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_TAKE    = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_DRAIN   = 3'd3,
		CMD_PAUSE   = 3'd4,
		CMD_READ    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_DROPPED = 2'd2,
		STAT_NONE    = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_STREAM
	} fsm_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ROW_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// one row per record; buffer 1 sits above buffer 0
	function automatic logic [ADDR_W-1:0] row_addr(input logic b, input logic [SLOT_W-1:0] slot);
		logic [ADDR_W-1:0] base;
		base = b ? ADDR_W'(RECS_PER_BUFFER) : '0;
		row_addr = base + ADDR_W'(slot);
	endfunction

endpackage

FILE: design/ppl_ifs.sv
interface ppl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] timestamp_us;
	logic [31:0] sample_time_us;
	logic [7:0]  sensor_id;
	logic [7:0]  accuracy;
	logic [31:0] value_a;
	logic [31:0] value_b;
	logic [31:0] value_c;
	logic [31:0] value_d;
	logic        buffer_sel;
	logic [7:0]  record_index;
	logic        flag;

	modport source (output valid, cmd, timestamp_us, sample_time_us, sensor_id, accuracy,
		value_a, value_b, value_c, value_d, buffer_sel, record_index, flag, input ready);
	modport sink (input valid, cmd, timestamp_us, sample_time_us, sensor_id, accuracy,
		value_a, value_b, value_c, value_d, buffer_sel, record_index, flag, output ready);
endinterface

interface ppl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        buffer_index;
	logic [8:0]  fill_count;
	logic [31:0] dropped_count;
	logic [31:0] written_count;
	logic [31:0] data_word;
	logic        last;

	modport source (output valid, status, buffer_index, fill_count, dropped_count,
		written_count, data_word, last, input ready);
	modport sink (input valid, status, buffer_index, fill_count, dropped_count,
		written_count, data_word, last, output ready);
endinterface

interface ppl_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: design/ping_pong_record_logger_unit.sv
// Ping-pong record logger. Records are pushed into the active one of two buffers held
// in a single RAM of 2 x 256 rows, one 224-bit row per record, written whole by one RAM
// write. Push, take, release, drain-done, pause and unused commands each yield one
// response and can be accepted every cycle while the response register is free or being
// taken. A read of a slot below the buffer's fill issues one RAM row read and then
// streams the seven words (time, sample time, seq/accuracy/id, four values) on the
// 32-bit response port, one per cycle under the same condition, holding the request side
// until the last word. Record RAM is not cleared at reset; only slots below the fill
// count are ever read. The enable register is written on the cfg channel, always ready.
module ping_pong_record_logger_unit import ppl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ppl_req_if.sink   req,
	ppl_rsp_if.source rsp,
	ppl_cfg_if.sink   cfg
);

	mem_req_t         mreq;
	logic [ROW_W-1:0] rdata;

	ppl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	ppl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_rec_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (rdata)
	);

endmodule

FILE: design/ppl_ram.sv
module ppl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/ppl_ctrl.sv
module ppl_ctrl import ppl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ppl_req_if.sink          req,
	ppl_rsp_if.source        rsp,
	ppl_cfg_if.sink          cfg,
	output mem_req_t         mreq,
	input  logic [ROW_W-1:0] rdata
);

	fsm_t              fsm_q, fsm_d;
	logic [WIDX_W-1:0] widx_q, widx_d;
	logic              sel_q, sel_d;
	logic              en_q;
	logic              paused_q, paused_d;
	logic              active_q, active_d;
	logic [1:0]        pend_q, pend_d;
	logic [1:0]        busy_q, busy_d;
	logic [FILL_W-1:0] fill_q [2];
	logic [FILL_W-1:0] fill_d [2];
	logic [15:0]       seq_q, seq_d;
	logic [31:0]       drop_q, drop_d;
	logic [31:0]       wr_q, wr_d;

	logic              vld_q;
	logic [1:0]        status_q;
	logic              bidx_q;
	logic [8:0]        fillo_q;
	logic [31:0]       word_q;
	logic              last_q;

	logic              ofree;
	logic              acc;
	logic              push_go;
	logic              res_load;
	status_t           res_status;
	logic              res_buf;
	logic [31:0]       res_word;
	logic              res_last;
	logic [8:0]        res_fill;
	logic              oth;

	assign ofree     = !vld_q || rsp.ready;
	assign req.ready = (fsm_q == FSM_IDLE) && ofree;
	assign acc       = req.valid && req.ready;
	assign push_go   = acc && (req.cmd == CMD_PUSH) && en_q && !paused_q;
	assign cfg.ready = 1'b1;
	assign oth       = ~active_q;

	always_comb begin
		fsm_d      = fsm_q;
		widx_d     = widx_q;
		sel_d      = sel_q;
		paused_d   = paused_q;
		active_d   = active_q;
		pend_d     = pend_q;
		busy_d     = busy_q;
		fill_d     = fill_q;
		seq_d      = seq_q;
		drop_d     = drop_q;
		wr_d       = wr_q;
		mreq       = '0;
		res_load   = 1'b0;
		res_status = STAT_DONE;
		res_buf    = active_q;
		res_word   = '0;
		res_last   = 1'b1;

		case (fsm_q)
			FSM_IDLE: begin
				if (acc) begin
					res_load = 1'b1;
					case (cmd_t'(req.cmd))
						CMD_PUSH: begin
							mreq.wdata = {req.value_d, req.value_c, req.value_b, req.value_a,
								seq_q, req.accuracy, req.sensor_id,
								req.sample_time_us, req.timestamp_us};
							if (!en_q || paused_q) begin
								res_status = STAT_IGNORED;
							end else begin
								seq_d = seq_q + 16'd1;
								if (fill_q[active_q] == FILL_W'(RECS_PER_BUFFER)) begin
									if (pend_q[oth] || busy_q[oth]) begin
										drop_d     = drop_q + 32'd1;
										res_status = STAT_DROPPED;
									end else begin
										// swap: full buffer waits for the consumer
										pend_d[active_q] = 1'b1;
										active_d         = oth;
										res_buf          = oth;
										fill_d[oth]      = FILL_W'(1);
										mreq.we          = 1'b1;
										mreq.waddr       = row_addr(oth, '0);
									end
								end else begin
									fill_d[active_q] = fill_q[active_q] + FILL_W'(1);
									mreq.we          = 1'b1;
									mreq.waddr       = row_addr(active_q, SLOT_W'(fill_q[active_q]));
								end
							end
						end
						CMD_TAKE: begin
							if (pend_q[0] && !busy_q[0]) begin
								busy_d[0] = 1'b1;
								pend_d[0] = 1'b0;
								res_buf   = 1'b0;
							end else if (pend_q[1] && !busy_q[1]) begin
								busy_d[1] = 1'b1;
								pend_d[1] = 1'b0;
								res_buf   = 1'b1;
							end else begin
								res_status = STAT_NONE;
								res_buf    = 1'b0;
							end
						end
						CMD_RELEASE: begin
							pend_d[req.buffer_sel] = 1'b1;
							busy_d[req.buffer_sel] = 1'b0;
							res_buf                = req.buffer_sel;
						end
						CMD_DRAIN: begin
							if (req.flag) begin
								wr_d = wr_q + 32'(fill_q[req.buffer_sel]);
							end
							fill_d[req.buffer_sel] = '0;
							busy_d[req.buffer_sel] = 1'b0;
							res_buf                = req.buffer_sel;
						end
						CMD_PAUSE: begin
							if (req.flag && !paused_q) begin
								for (int i = 0; i < 2; i++) begin
									if (!busy_q[i]) begin
										fill_d[i] = '0;
										pend_d[i] = 1'b0;
									end
								end
							end
							paused_d = req.flag;
						end
						CMD_READ: begin
							res_buf = req.buffer_sel;
							if (32'(req.record_index) >= 32'(fill_q[req.buffer_sel]) ||
								32'(req.record_index) >= 32'(RECS_PER_BUFFER)) begin
								res_status = STAT_NONE;
							end else begin
								res_load   = 1'b0;
								mreq.re    = 1'b1;
								mreq.raddr = row_addr(req.buffer_sel, SLOT_W'(req.record_index));
								sel_d      = req.buffer_sel;
								widx_d     = '0;
								fsm_d      = FSM_STREAM;
							end
						end
						default: begin
							res_status = STAT_IGNORED;
						end
					endcase
				end
			end
			FSM_STREAM: begin
				// row stays on the RAM output; hand out one word per free slot
				res_buf = sel_q;
				if (ofree) begin
					res_load = 1'b1;
					res_word = rdata[widx_q * WORD_W +: WORD_W];
					res_last = (widx_q == WIDX_W'(WORDS_PER_REC - 1));
					widx_d   = widx_q + WIDX_W'(1);
					if (res_last) begin
						fsm_d = FSM_IDLE;
					end
				end
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase

		res_fill = FILL_OUT_W'(fill_d[res_buf]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= FSM_IDLE;
			widx_q    <= '0;
			sel_q     <= 1'b0;
			en_q      <= 1'b1;
			paused_q  <= 1'b0;
			active_q  <= 1'b0;
			pend_q    <= '0;
			busy_q    <= '0;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			seq_q     <= '0;
			drop_q    <= '0;
			wr_q      <= '0;
			vld_q     <= 1'b0;
		end else begin
			fsm_q    <= fsm_d;
			widx_q   <= widx_d;
			sel_q    <= sel_d;
			paused_q <= paused_d;
			active_q <= active_d;
			pend_q   <= pend_d;
			busy_q   <= busy_d;
			fill_q   <= fill_d;
			seq_q    <= seq_d;
			drop_q   <= drop_d;
			wr_q     <= wr_d;
			if (cfg.valid && cfg.ready) begin
				en_q <= cfg.data;
			end
			if (res_load) begin
				vld_q <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			bidx_q   <= res_buf;
			fillo_q  <= res_fill;
			word_q   <= res_word;
			last_q   <= res_last;
		end
	end

	assign rsp.valid         = vld_q;
	assign rsp.status        = status_q;
	assign rsp.buffer_index  = bidx_q;
	assign rsp.fill_count    = fillo_q;
	assign rsp.dropped_count = drop_q;
	assign rsp.written_count = wr_q;
	assign rsp.data_word     = word_q;
	assign rsp.last          = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FILL_W'(RECS_PER_BUFFER) && fill_q[1] <= FILL_W'(RECS_PER_BUFFER))
		else $error("fill count above buffer size");

	a_read_streams: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.re |=> fsm_q == FSM_STREAM && widx_q == '0)
		else $error("row read not followed by word stream");

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == FSM_STREAM |-> widx_q < WIDX_W'(WORDS_PER_REC))
		else $error("word index out of range");

	a_seq_only_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != $past(seq_q) |-> $past(push_go))
		else $error("sequence number moved without an accepted push");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.we && mreq.re))
		else $error("record write and read in one cycle");

endmodule

FILE: tb/tb_ping_pong_record_logger_unit.sv
`timescale 1ns / 100ps

module tb_ping_pong_record_logger_unit;
	import ppl_pkg::*;

	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_REQS   = 100;
	localparam int BURST_PUSHES  = 40;
	localparam int LATE_PUSHES   = 20;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] ts;
		logic [31:0] st;
		logic [7:0]  id;
		logic [7:0]  acc;
		logic [31:0] va;
		logic [31:0] vb;
		logic [31:0] vc;
		logic [31:0] vd;
		logic        sel;
		logic [7:0]  idx;
		logic        flag;
	} log_req_t;

	typedef struct {
		logic [1:0]  status;
		logic        buf_idx;
		logic [8:0]  fill_cnt;
		logic [31:0] dropped;
		logic [31:0] written;
		logic [31:0] word;
		logic        last;
	} log_reply_t;

	// Shadow of the two buffers; each accepted request queues the replies it should produce.
	class pingpong_tracker;
		int unsigned fill [2];
		bit          pend [2];
		bit          busy [2];
		bit          act;
		bit          paused;
		bit          enabled;
		logic [15:0] seq;
		logic [31:0] dropped;
		logic [31:0] written;
		logic [31:0] rec_store [2][RECS_PER_BUFFER][WORDS_PER_REC];
		log_reply_t  replies_due [$];
		int          errors;
		int          n_reqs;
		int          n_replies;
		int          n_reads;
		int          n_drops;
		int          n_ignored;

		function new();
			enabled = 1'b1;
			seq     = '0;
			dropped = '0;
			written = '0;
		endfunction

		function int outstanding();
			return replies_due.size();
		endfunction

		function void queue_reply(status_t st, bit b, logic [31:0] word, bit is_last);
			log_reply_t e;
			e.status   = st;
			e.buf_idx  = b;
			e.fill_cnt = 9'(fill[b]);
			e.dropped  = dropped;
			e.written  = written;
			e.word     = word;
			e.last     = is_last;
			replies_due.push_back(e);
		endfunction

		function void predict_replies(log_req_t r);
			bit          a;
			logic [15:0] seq_no;
			n_reqs++;
			case (r.cmd)
			CMD_PUSH: begin
				a = act;
				if (!enabled || paused) begin
					n_ignored++;
					queue_reply(STAT_IGNORED, a, '0, 1'b1);
					return;
				end
				// sequence number is used up even if the record gets dropped
				seq_no = seq;
				seq    = seq + 16'd1;
				if (fill[a] >= RECS_PER_BUFFER) begin
					if (pend[!a] || busy[!a]) begin
						dropped = dropped + 32'd1;
						n_drops++;
						queue_reply(STAT_DROPPED, a, '0, 1'b1);
						return;
					end
					pend[a]  = 1'b1;
					fill[!a] = 0;
					act      = !a;
					a        = !a;
				end
				rec_store[a][fill[a]][0] = r.ts;
				rec_store[a][fill[a]][1] = r.st;
				rec_store[a][fill[a]][2] = {seq_no, r.acc, r.id};
				rec_store[a][fill[a]][3] = r.va;
				rec_store[a][fill[a]][4] = r.vb;
				rec_store[a][fill[a]][5] = r.vc;
				rec_store[a][fill[a]][6] = r.vd;
				fill[a]++;
				queue_reply(STAT_DONE, a, '0, 1'b1);
			end
			CMD_TAKE: begin
				for (int i = 0; i < 2; i++) begin
					if (pend[i] && !busy[i]) begin
						busy[i] = 1'b1;
						pend[i] = 1'b0;
						queue_reply(STAT_DONE, i[0], '0, 1'b1);
						return;
					end
				end
				queue_reply(STAT_NONE, 1'b0, '0, 1'b1);
			end
			CMD_RELEASE: begin
				pend[r.sel] = 1'b1;
				busy[r.sel] = 1'b0;
				queue_reply(STAT_DONE, r.sel, '0, 1'b1);
			end
			CMD_DRAIN: begin
				if (r.flag)
					written = written + fill[r.sel];
				fill[r.sel] = 0;
				busy[r.sel] = 1'b0;
				queue_reply(STAT_DONE, r.sel, '0, 1'b1);
			end
			CMD_PAUSE: begin
				// only the rising edge of pause flushes idle buffers
				if (r.flag && !paused) begin
					for (int i = 0; i < 2; i++) begin
						if (!busy[i]) begin
							fill[i] = 0;
							pend[i] = 1'b0;
						end
					end
				end
				paused = r.flag;
				queue_reply(STAT_DONE, act, '0, 1'b1);
			end
			CMD_READ: begin
				if (r.idx >= fill[r.sel]) begin
					queue_reply(STAT_NONE, r.sel, '0, 1'b1);
				end else begin
					n_reads++;
					for (int k = 0; k < WORDS_PER_REC; k++)
						queue_reply(STAT_DONE, r.sel, rec_store[r.sel][r.idx][k],
							k == WORDS_PER_REC - 1);
				end
			end
			default: begin
				queue_reply(STAT_IGNORED, act, '0, 1'b1);
			end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(log_reply_t got);
			log_reply_t want;
			if (replies_due.size() == 0) begin
				$error("response with none expected: status %0d data_word 0x%0h",
					got.status, got.word);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			n_replies++;
			compare_field("status", want.status, got.status);
			compare_field("buffer_index", want.buf_idx, got.buf_idx);
			compare_field("fill_count", want.fill_cnt, got.fill_cnt);
			compare_field("dropped_count", want.dropped, got.dropped);
			compare_field("written_count", want.written, got.written);
			compare_field("data_word", want.word, got.word);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ppl_req_if req_ch ();
	ppl_rsp_if rsp_ch ();
	ppl_cfg_if cfg_ch ();

	ping_pong_record_logger_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pingpong_tracker sb;
	bit quiet;
	bit hold_req;
	int cycle_count;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		2: return 32'h8000_0000;
		default: return $urandom;
		endcase
	endfunction

	function automatic log_req_t random_req(logic [2:0] c);
		log_req_t r;
		r.cmd  = c;
		r.ts   = pick_word();
		r.st   = pick_word();
		r.id   = 8'($urandom);
		r.acc  = 8'($urandom);
		r.va   = pick_word();
		r.vb   = pick_word();
		r.vc   = pick_word();
		r.vd   = pick_word();
		r.sel  = 1'($urandom_range(1));
		r.idx  = 8'($urandom_range(255));
		r.flag = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic log_req_t flat_push(logic [31:0] w);
		log_req_t r;
		r      = random_req(CMD_PUSH);
		r.ts   = w;
		r.st   = w;
		r.id   = w[7:0];
		r.acc  = w[7:0];
		r.va   = w;
		r.vb   = w;
		r.vc   = w;
		r.vd   = w;
		r.sel  = w[0];
		r.idx  = w[7:0];
		r.flag = w[0];
		return r;
	endfunction

	task automatic send(log_req_t r);
		int gap;
		@(negedge clk);
		req_ch.cmd            = r.cmd;
		req_ch.timestamp_us   = r.ts;
		req_ch.sample_time_us = r.st;
		req_ch.sensor_id      = r.id;
		req_ch.accuracy       = r.acc;
		req_ch.value_a        = r.va;
		req_ch.value_b        = r.vb;
		req_ch.value_c        = r.vc;
		req_ch.value_d        = r.vd;
		req_ch.buffer_sel     = r.sel;
		req_ch.record_index   = r.idx;
		req_ch.flag           = r.flag;
		req_ch.valid          = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		sb.predict_replies(r);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic issue(logic [2:0] c, bit sel, logic [7:0] idx, bit flag);
		log_req_t r;
		r      = random_req(c);
		r.sel  = sel;
		r.idx  = idx;
		r.flag = flag;
		send(r);
	endtask

	task automatic push_records(int n);
		repeat (n) send(random_req(CMD_PUSH));
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		settle();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.enabled = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic random_mix(int n);
		int  base;
		int  pick;
		bit  sel;
		int  f;
		base = sb.n_reqs;
		while (sb.n_reqs < base + n) begin
			pick = $urandom_range(99);
			sel  = 1'($urandom_range(1));
			if (pick < 40) begin
				push_records($urandom_range(1, 12));
			end else if (pick < 62) begin
				f = sb.fill[sel];
				if (f > 0 && $urandom_range(3) != 0)
					issue(CMD_READ, sel, 8'($urandom_range(f - 1)), 1'($urandom));
				else
					issue(CMD_READ, sel, 8'($urandom_range(255)), 1'($urandom));
			end else if (pick < 70) begin
				issue(CMD_TAKE, sel, 8'($urandom), 1'($urandom));
			end else if (pick < 77) begin
				issue(CMD_RELEASE, sel, 8'($urandom), 1'($urandom));
			end else if (pick < 86) begin
				issue(CMD_DRAIN, sel, 8'($urandom), $urandom_range(3) != 0);
			end else if (pick < 93) begin
				// stay paused only briefly
				if (sb.paused)
					issue(CMD_PAUSE, sel, 8'($urandom), $urandom_range(3) == 0);
				else
					issue(CMD_PAUSE, sel, 8'($urandom), $urandom_range(2) == 0);
			end else begin
				issue($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, sel, 8'($urandom),
					1'($urandom));
			end
		end
	endtask

	// response side: random stalls, plus one long hold requested by the stimulus
	initial begin
		int stall_left;
		int hold_left;
		stall_left   = 0;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
				stall_left   = ($urandom_range(3) == 0) ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		log_reply_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status   = rsp_ch.status;
			got.buf_idx  = rsp_ch.buffer_index;
			got.fill_cnt = rsp_ch.fill_count;
			got.dropped  = rsp_ch.dropped_count;
			got.written  = rsp_ch.written_count;
			got.word     = rsp_ch.data_word;
			got.last     = rsp_ch.last;
			sb.check_reply(got);
		end
	end

	initial begin
		req_ch.valid          = 1'b0;
		req_ch.cmd            = '0;
		req_ch.timestamp_us   = '0;
		req_ch.sample_time_us = '0;
		req_ch.sensor_id      = '0;
		req_ch.accuracy       = '0;
		req_ch.value_a        = '0;
		req_ch.value_b        = '0;
		req_ch.value_c        = '0;
		req_ch.value_d        = '0;
		req_ch.buffer_sel     = 1'b0;
		req_ch.record_index   = '0;
		req_ch.flag           = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.data           = 1'b0;
		quiet                 = 1'b0;
		hold_req              = 1'b0;
		cycle_count           = 0;
		sb                    = new();
		arst_n                = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_enable(1'b1);

		// directed: empty buffers, field extremes, take/release/drain/pause corners
		issue(CMD_TAKE, 1'b0, 8'd0, 1'b0);
		issue(CMD_READ, 1'b0, 8'd0, 1'b0);
		send(flat_push('1));
		send(flat_push('0));
		issue(CMD_READ, 1'b0, 8'd0, 1'b1);
		issue(CMD_READ, 1'b0, 8'd1, 1'b0);
		issue(CMD_READ, 1'b0, 8'd255, 1'b1);
		issue(CMD_RELEASE, 1'b1, 8'd0, 1'b0);
		issue(CMD_TAKE, 1'b0, 8'd0, 1'b0);
		send(random_req(CMD_PUSH));
		issue(CMD_DRAIN, 1'b1, 8'd0, 1'b1);
		issue(CMD_DRAIN, 1'b0, 8'd0, 1'b1);
		send(random_req(CMD_PUSH));
		issue(CMD_RELEASE, 1'b0, 8'd0, 1'b0);
		issue(CMD_TAKE, 1'b1, 8'd0, 1'b1);
		issue(CMD_PAUSE, 1'b0, 8'd0, 1'b1);
		send(random_req(CMD_PUSH));
		issue(CMD_PAUSE, 1'b1, 8'd0, 1'b1);
		issue(CMD_PAUSE, 1'b0, 8'd0, 1'b0);
		issue(CMD_READ, 1'b0, 8'd0, 1'b0);
		issue(CMD_SPARE_6, 1'b0, 8'd0, 1'b0);
		issue(CMD_SPARE_7, 1'b1, 8'hff, 1'b1);
		issue(CMD_DRAIN, 1'b0, 8'd0, 1'b0);
		send(random_req(CMD_PUSH));

		// logging off: pushes are ignored, other commands still act
		write_enable(1'b0);
		random_mix(15);
		write_enable(1'b1);

		// push a burst with the response side held off, so the request side backs up
		hold_req = 1'b1;
		quiet    = 1'b1;
		push_records(BURST_PUSHES);
		quiet = 1'b0;
		issue(CMD_TAKE, 1'b0, 8'd0, 1'b0);
		issue(CMD_READ, 1'b0, 8'd0, 1'b0);
		issue(CMD_READ, 1'b0, 8'd128, 1'b0);
		issue(CMD_READ, 1'b0, 8'd255, 1'b0);
		issue(CMD_READ, 1'b1, 8'd255, 1'b0);
		issue(CMD_RELEASE, 1'b0, 8'd0, 1'b0);
		issue(CMD_TAKE, 1'b1, 8'd0, 1'b0);
		issue(CMD_DRAIN, 1'b0, 8'd0, 1'b1);
		send(random_req(CMD_PUSH));
		issue(CMD_TAKE, 1'b0, 8'd0, 1'b0);
		// back-to-back pushes with no gaps
		quiet = 1'b1;
		push_records(LATE_PUSHES);
		quiet = 1'b0;
		issue(CMD_DRAIN, 1'b1, 8'd0, 1'b0);

		random_mix(RANDOM_REQS);
		settle();

		$display("Covered %0d requests and %0d responses: %0d record reads, %0d drops,",
			sb.n_reqs, sb.n_replies, sb.n_reads, sb.n_drops);
		$display("%0d ignored pushes, %0d records reported written",
			sb.n_ignored, sb.written);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
